// ===== sv/ps2mct_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, reset values, register indexes, phase codes and item types.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int COORD_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int BTN_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W      = COORD_W + 2;

    // Bit of the first packet byte that is always set by the mouse.
    localparam int SYNC_BIT = 3;

    localparam logic [COORD_W-1:0] MAX_X_RST = 12'd1023;
    localparam logic [COORD_W-1:0] MAX_Y_RST = 12'd767;
    localparam logic [COORD_W-1:0] POS_X_RST = 12'd512;
    localparam logic [COORD_W-1:0] POS_Y_RST = 12'd384;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 1'b1;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2
    } phase_t;

    typedef struct packed {
        logic               action;
        logic [BYTE_W-1:0]  data_byte;
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
    } item_t;

endpackage

// ===== sv/ps2mct_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface ps2mct_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [ps2mct_pkg::BYTE_W-1:0]    data_byte;
    logic [ps2mct_pkg::COORD_W-1:0]   new_x;
    logic [ps2mct_pkg::COORD_W-1:0]   new_y;

    modport source (output valid, output action, output data_byte, output new_x,
                    output new_y, input ready);
    modport sink   (input valid, input action, input data_byte, input new_x,
                    input new_y, output ready);
endinterface

interface ps2mct_out_if;
    logic                             valid;
    logic                             ready;
    logic [ps2mct_pkg::COORD_W-1:0]   cursor_x;
    logic [ps2mct_pkg::COORD_W-1:0]   cursor_y;
    logic [ps2mct_pkg::BTN_W-1:0]     button_bits;
    logic                             packet_done;

    modport source (output valid, output cursor_x, output cursor_y,
                    output button_bits, output packet_done, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input button_bits, input packet_done, output ready);
endinterface

// ===== sv/ps2mct_in_stage.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker input stage
// Registers one accepted item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module ps2mct_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    ps2mct_in_if.sink           in_ch,
    input  logic                take,
    output logic                valid,
    output ps2mct_pkg::item_t   item
);
    import ps2mct_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_ch.ready = !valid_reg || take;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.action    <= in_ch.action;
            item_reg.data_byte <= in_ch.data_byte;
            item_reg.new_x     <= in_ch.new_x;
            item_reg.new_y     <= in_ch.new_y;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== sv/ps2mct_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker core
// Packet phase tracking, cursor update with clamping and the result register.
// ----------------------------------------------------------------------------
module ps2mct_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  item_valid,
    input  ps2mct_pkg::item_t                     item,
    output logic                                  take,
    ps2mct_out_if.source                          out_ch
);
    import ps2mct_pkg::*;

    logic [COORD_W-1:0] max_x_reg;
    logic [COORD_W-1:0] max_y_reg;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [BTN_W-1:0]   held_buttons_reg;
    logic [BYTE_W-1:0]  held_dx_reg;
    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_x_next;
    logic [COORD_W-1:0] pos_y_reg;
    logic [COORD_W-1:0] pos_y_next;
    logic [BTN_W-1:0]   buttons_reg;
    logic [BTN_W-1:0]   buttons_next;
    logic               done_next;
    logic               hold_first;
    logic               hold_dx;

    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [BTN_W-1:0]   out_buttons_reg;
    logic               out_done_reg;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] sum,
        input logic [COORD_W-1:0]      hi
    );
        logic [COORD_W-1:0] res;
        if (sum < 0)
        begin
            res = '0;
        end
        else if (sum > $signed({2'b00, hi}))
        begin
            res = hi;
        end
        else
        begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

    assign take = item_valid && (!out_valid_reg || out_ch.ready);

    assign sum_x = $signed({2'b00, pos_x_reg})
                 + $signed({{(SUM_W-BYTE_W){held_dx_reg[BYTE_W-1]}}, held_dx_reg});
    assign sum_y = $signed({2'b00, pos_y_reg})
                 - $signed({{(SUM_W-BYTE_W){item.data_byte[BYTE_W-1]}}, item.data_byte});

    always_comb
    begin
        phase_next = phase_reg;
        if (!item.action)
        begin
            unique case (phase_reg)
                PH_DX:
                begin
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = item.data_byte[SYNC_BIT] ? PH_DX : PH_FIRST;
                end
            endcase
        end
    end

    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        done_next    = 1'b0;
        hold_first   = 1'b0;
        hold_dx      = 1'b0;
        if (item.action)
        begin
            pos_x_next = item.new_x;
            pos_y_next = item.new_y;
        end
        else
        begin
            unique case (phase_reg)
                PH_DX:
                begin
                    hold_dx = 1'b1;
                end
                PH_DY:
                begin
                    buttons_next = held_buttons_reg;
                    pos_x_next   = clamp_coord(sum_x, max_x_reg);
                    pos_y_next   = clamp_coord(sum_y, max_y_reg);
                    done_next    = 1'b1;
                end
                default:
                begin
                    hold_first = item.data_byte[SYNC_BIT];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RST;
            max_y_reg <= MAX_Y_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_X: max_x_reg <= cfg_data[COORD_W-1:0];
                CFG_MAX_Y: max_y_reg <= cfg_data[COORD_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            pos_x_reg   <= POS_X_RST;
            pos_y_reg   <= POS_Y_RST;
            buttons_reg <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            buttons_reg <= buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hold_first)
        begin
            held_buttons_reg <= item.data_byte[BTN_W-1:0];
        end
        if (take && hold_dx)
        begin
            held_dx_reg <= item.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_x_reg       <= pos_x_next;
            out_y_reg       <= pos_y_next;
            out_buttons_reg <= buttons_next;
            out_done_reg    <= done_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.cursor_x    = out_x_reg;
    assign out_ch.cursor_y    = out_y_reg;
    assign out_ch.button_bits = out_buttons_reg;
    assign out_ch.packet_done = out_done_reg;

endmodule

// ===== sv/ps2_mouse_packet_cursor_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Assembles three-byte mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is not
// stalled and returns exactly one result item for each: the input register
// holds the item, then the packet and cursor logic writes the result register.
// Up to two items are held inside, so input stays open while a finished result
// waits to be taken. The user must write maximum coordinates through the
// configuration port while no items are in flight; the block does not check.
module ps2_mouse_packet_cursor_tracker_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ps2mct_pkg::CFG_DATA_W-1:0]     cfg_data,
    ps2mct_in_if.sink                             in_ch,
    ps2mct_out_if.source                          out_ch
);
    import ps2mct_pkg::*;

    logic  stage_valid;
    item_t stage_item;
    logic  stage_take;

    ps2mct_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .take  (stage_take),
        .valid (stage_valid),
        .item  (stage_item)
    );

    ps2mct_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (stage_valid),
        .item       (stage_item),
        .take       (stage_take),
        .out_ch     (out_ch)
    );

endmodule

// ===== sv/ps2mct_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker checker
// Port-level checks on item flow and result handshakes.
// ----------------------------------------------------------------------------
module ps2mct_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [ps2mct_pkg::COORD_W-1:0]      cursor_x,
    input  logic [ps2mct_pkg::COORD_W-1:0]      cursor_y,
    input  logic [ps2mct_pkg::BTN_W-1:0]        button_bits,
    input  logic                                packet_done
);
    import ps2mct_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A result is never offered without an item in flight.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != 2'd0))
        else $error("result offered with no item in flight");

    // At most two items are ever held inside the block.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3) && !((count_reg == 2'd2) && in_acc && !out_acc))
        else $error("more items in flight than the block can hold");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cursor_x) && $stable(cursor_y)
            && $stable(button_bits) && $stable(packet_done))
        else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mct_checker u_ps2mct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cursor_x    (out_ch.cursor_x),
    .cursor_y    (out_ch.cursor_y),
    .button_bits (out_ch.button_bits),
    .packet_done (out_ch.packet_done)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Streams mouse bytes and set-position items into the tracker under several
// clamp limits, with random gaps and a long output stall. Each result item is
// compared with a cycle-free model of the packet decoder and cursor.
// ----------------------------------------------------------------------------
module tb;
    import ps2mct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AT_RESULT = 120;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BTN_W-1:0]   btn;
        logic               done;
    } cursor_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  calm;

    ps2mct_in_if  in_ch();
    ps2mct_out_if out_ch();

    ps2_mouse_packet_cursor_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    item_t          mouse_items[$];
    cursor_result_t expected_cursors[$];
    int             error_count = 0;
    int             stall_cycles = 0;

    logic [COORD_W-1:0] lim_x;
    logic [COORD_W-1:0] lim_y;
    phase_t             phase;
    logic [BTN_W-1:0]   held_btn;
    logic [BYTE_W-1:0]  held_dx;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [BTN_W-1:0]   cur_btn;

    always #5 clk = ~clk;

    task automatic report(string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(int p, logic [COORD_W-1:0] hi);
        if (p < 0)
            return '0;
        if (p > int'(hi))
            return hi;
        return COORD_W'(p);
    endfunction

    function automatic cursor_result_t track_item(item_t it);
        cursor_result_t r;
        r.done = 1'b0;
        if (it.action) begin
            cur_x = it.new_x;
            cur_y = it.new_y;
        end
        else if (phase == PH_DX) begin
            held_dx = it.data_byte;
            phase = PH_DY;
        end
        else if (phase == PH_DY) begin
            phase = PH_FIRST;
            cur_btn = held_btn;
            cur_x = clamp_coord(int'(cur_x) + int'($signed(held_dx)), lim_x);
            cur_y = clamp_coord(int'(cur_y) - int'($signed(it.data_byte)), lim_y);
            r.done = 1'b1;
        end
        else if (it.data_byte[SYNC_BIT]) begin
            held_btn = it.data_byte[BTN_W-1:0];
            phase = PH_DX;
        end
        r.x = cur_x;
        r.y = cur_y;
        r.btn = cur_btn;
        return r;
    endfunction

    function automatic item_t mouse_byte(logic [BYTE_W-1:0] b);
        item_t it;
        it.action = 1'b0;
        it.data_byte = b;
        it.new_x = COORD_W'($urandom);
        it.new_y = COORD_W'($urandom);
        return it;
    endfunction

    function automatic item_t set_pos(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        item_t it;
        it.action = 1'b1;
        it.data_byte = BYTE_W'($urandom);
        it.new_x = x;
        it.new_y = y;
        return it;
    endfunction

    task automatic add_packet(logic [BYTE_W-1:0] b0, logic [BYTE_W-1:0] dx,
                              logic [BYTE_W-1:0] dy);
        mouse_items.push_back(mouse_byte(b0));
        mouse_items.push_back(mouse_byte(dx));
        mouse_items.push_back(mouse_byte(dy));
    endtask

    task automatic drain();
        while (mouse_items.size() != 0 || in_ch.valid || expected_cursors.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_X;
        cfg_data  <= mx;
        @(posedge clk);
        cfg_index <= CFG_MAX_Y;
        cfg_data  <= my;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lim_x = mx;
        lim_y = my;
        @(negedge clk);
    endtask

    task automatic add_random(int n);
        int count;
        int pick;
        logic [BYTE_W-1:0] b0;
        count = 0;
        while (count < n) begin
            pick = $urandom_range(99);
            b0 = BYTE_W'($urandom);
            if (pick < 70) begin
                b0[SYNC_BIT] = 1'b1;
                add_packet(b0, BYTE_W'($urandom), BYTE_W'($urandom));
                count += 3;
            end
            else if (pick < 80) begin
                mouse_items.push_back(set_pos(COORD_W'($urandom), COORD_W'($urandom)));
                count += 1;
            end
            else if (pick < 88) begin
                b0[SYNC_BIT] = 1'b1;
                mouse_items.push_back(mouse_byte(b0));
                mouse_items.push_back(set_pos(COORD_W'($urandom), COORD_W'($urandom)));
                mouse_items.push_back(mouse_byte(BYTE_W'($urandom)));
                count += 3;
            end
            else begin
                mouse_items.push_back(mouse_byte(b0));
                count += 1;
            end
        end
    endtask

    always @(posedge clk) begin
        item_t cur;
        item_t nxt;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end
        else begin
            if (in_ch.valid && in_ch.ready) begin
                cur.action = in_ch.action;
                cur.data_byte = in_ch.data_byte;
                cur.new_x = in_ch.new_x;
                cur.new_y = in_ch.new_y;
                expected_cursors.push_back(track_item(cur));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (mouse_items.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                    nxt = mouse_items.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.action    <= nxt.action;
                    in_ch.data_byte <= nxt.data_byte;
                    in_ch.new_x     <= nxt.new_x;
                    in_ch.new_y     <= nxt.new_y;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        cursor_result_t exp_r;
        int results_seen;
        int hold_left;
        bit hold_done;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            results_seen = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_cursors.size() == 0) begin
                    report("result item arrived with no expectation waiting");
                end
                else begin
                    exp_r = expected_cursors.pop_front();
                    if (out_ch.cursor_x !== exp_r.x)
                        report($sformatf("cursor_x %0d, expected %0d",
                                         out_ch.cursor_x, exp_r.x));
                    if (out_ch.cursor_y !== exp_r.y)
                        report($sformatf("cursor_y %0d, expected %0d",
                                         out_ch.cursor_y, exp_r.y));
                    if (out_ch.button_bits !== exp_r.btn)
                        report($sformatf("button_bits %0d, expected %0d",
                                         out_ch.button_bits, exp_r.btn));
                    if (out_ch.packet_done !== exp_r.done)
                        report($sformatf("packet_done %0d, expected %0d",
                                         out_ch.packet_done, exp_r.done));
                end
            end
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 12);
            if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.data_byte = '0;
        in_ch.new_x = '0;
        in_ch.new_y = '0;
        out_ch.ready = 1'b0;
        lim_x = MAX_X_RST;
        lim_y = MAX_Y_RST;
        phase = PH_FIRST;
        held_btn = '0;
        held_dx = '0;
        cur_x = POS_X_RST;
        cur_y = POS_Y_RST;
        cur_btn = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limits first: clamping at both ends, stale first bytes, and a
        // set-position landing in the middle of a packet.
        mouse_items.push_back(set_pos(12'd0, 12'd0));
        mouse_items.push_back(mouse_byte(8'h00));
        mouse_items.push_back(mouse_byte(8'hF7));
        add_packet(8'h08, 8'h80, 8'h01);
        mouse_items.push_back(set_pos(12'd4095, 12'd4095));
        add_packet(8'h09, 8'h00, 8'h00);
        add_packet(8'hFF, 8'h7F, 8'h80);
        mouse_items.push_back(set_pos(POS_X_RST, POS_Y_RST));
        add_packet(8'h0A, 8'h81, 8'h7F);
        mouse_items.push_back(mouse_byte(8'h2C));
        mouse_items.push_back(set_pos(12'hAAA, 12'h555));
        mouse_items.push_back(mouse_byte(8'h10));
        mouse_items.push_back(set_pos(12'h555, 12'hAAA));
        mouse_items.push_back(mouse_byte(8'hF0));
        add_packet(8'h3E, 8'h7F, 8'h7F);

        write_limits(12'd4095, 12'd4095);
        add_random(200);

        write_limits(12'd1, 12'd1);
        calm <= 1'b1;
        add_random(150);

        write_limits(COORD_W'($urandom_range(4095, 1)), COORD_W'($urandom_range(4095, 1)));
        calm <= 1'b0;
        add_random(150);

        write_limits(12'd4095, 12'd1);
        add_random(150);

        drain();
        repeat (6) @(posedge clk);
        if (expected_cursors.size() != 0)
            report($sformatf("%0d expected result items never arrived",
                             expected_cursors.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ps2mct_pkg.sv
sv/ps2mct_if.sv
sv/ps2mct_in_stage.sv
sv/ps2mct_core.sv
sv/ps2_mouse_packet_cursor_tracker_unit.sv
sv/ps2mct_checker.sv
test/tb.sv
